// File: hw/rtl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, constants and the CRC byte update for the read request framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

  localparam int unsigned FrameLen   = 8;
  localparam int unsigned BodyLen    = 6;
  localparam int unsigned IdxW       = $clog2(FrameLen);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0]  FuncReadHolding = 8'h03;
  localparam logic [7:0]  SlaveReset      = 8'd170;
  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam logic [15:0] CrcPoly         = 16'hA001;

  typedef struct packed {
    logic [7:0]  slave;
    logic [15:0] addr;
    logic [15:0] count;
  } req_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

// File: hw/rtl/mrf_front.sv
// ----------------------------------------------------------------------------
// mrf_front
// Request intake: holds the slave address register and stages each request.
// ----------------------------------------------------------------------------
module mrf_front
  import mrf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] start_address_i,
  input  logic [15:0] register_count_i,
  output logic        req_valid_o,
  input  logic        req_ready_i,
  output req_t        req_o
);

  logic [7:0] slave_q, slave_d;
  logic       vld_q, vld_d;
  req_t       req_q, req_d;
  logic       take;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !vld_q || req_ready_i;
  assign take        = in_valid_i && in_ready_o;

  always_comb begin
    slave_d = slave_q;
    if (cfg_valid_i) begin
      slave_d = cfg_data_i;
    end
    vld_d = vld_q;
    if (req_ready_i) begin
      vld_d = 1'b0;
    end
    if (take) begin
      vld_d = 1'b1;
    end
    req_d = req_q;
    if (take) begin
      req_d.slave = slave_q;
      req_d.addr  = start_address_i;
      req_d.count = register_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q <= SlaveReset;
      vld_q   <= 1'b0;
    end else begin
      slave_q <= slave_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign req_valid_o = vld_q;
  assign req_o       = req_q;

endmodule

// File: hw/rtl/mrf_queue.sv
// ----------------------------------------------------------------------------
// mrf_queue
// Short request queue between intake and frame serializer.
// ----------------------------------------------------------------------------
module mrf_queue
  import mrf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  req_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output req_t pop_data_o
);

  req_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = cnt_q != QCntW'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/mrf_back.sv
// ----------------------------------------------------------------------------
// mrf_back
// Frame serializer: emits eight bytes per request, CRC built one byte a cycle unless the output stalls.
// ----------------------------------------------------------------------------
module mrf_back
  import mrf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  req_t       req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       last_byte_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameLen - 1);
  localparam logic [IdxW-1:0] BodyEnd = IdxW'(BodyLen);

  req_t            req_q, req_d;
  logic            busy_q, busy_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     crc_q, crc_d;
  logic            ovld_q, ovld_d;
  logic [7:0]      obyte_q, obyte_d;
  logic            olast_q, olast_d;

  logic        ld, emit, pop;
  logic [7:0]  byte_sel;
  logic [15:0] crc_base, crc_next;

  assign ld          = !ovld_q || out_ready_i;
  assign emit        = busy_q && ld;
  assign req_ready_o = !busy_q || (emit && idx_q == LastIdx);
  assign pop         = req_valid_i && req_ready_o;

  always_comb begin
    case (idx_q)
      3'd0:    byte_sel = req_q.slave;
      3'd1:    byte_sel = FuncReadHolding;
      3'd2:    byte_sel = req_q.addr[15:8];
      3'd3:    byte_sel = req_q.addr[7:0];
      3'd4:    byte_sel = req_q.count[15:8];
      3'd5:    byte_sel = req_q.count[7:0];
      3'd6:    byte_sel = crc_q[7:0];
      default: byte_sel = crc_q[15:8];
    endcase
    crc_base = (idx_q == '0) ? CrcInit : crc_q;
    crc_next = crc16_byte(crc_base, byte_sel);
  end

  always_comb begin
    req_d   = pop ? req_i : req_q;
    busy_d  = busy_q;
    idx_d   = idx_q;
    crc_d   = crc_q;
    ovld_d  = ovld_q;
    obyte_d = obyte_q;
    olast_d = olast_q;
    if (ld) begin
      ovld_d = busy_q;
    end
    if (emit) begin
      obyte_d = byte_sel;
      olast_d = idx_q == LastIdx;
      idx_d   = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
      if (idx_q < BodyEnd) begin
        crc_d = crc_next;
      end
      if (idx_q == LastIdx) begin
        busy_d = 1'b0;
      end
    end
    if (pop) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    crc_q   <= crc_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o  = ovld_q;
  assign frame_byte_o = obyte_q;
  assign last_byte_o  = olast_q;

  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> idx_q == '0)
    else $error("byte index not at frame start while idle");

  a_pop_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !busy_q || idx_q == LastIdx)
    else $error("request taken in the middle of a frame");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && idx_q == LastIdx |=> ovld_q && olast_q)
    else $error("eighth byte not flagged as last");

endmodule

// File: hw/rtl/modbus_read_request_framer.sv
// ----------------------------------------------------------------------------
// modbus_read_request_framer
// Modbus RTU read holding registers request framer with CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Payload
// cfg       in   cfg_valid_i/cfg_ready_o  cfg_data_i (slave address)
// in        in   in_valid_i/in_ready_o    start_address_i, register_count_i
// out       out  out_valid_o/out_ready_i  frame_byte_o, last_byte_o
//
// Each request gives eight output bytes, one per cycle unless the output stalls;
// a new request is taken as the last byte of a frame loads, so frames run back to back.
// A request passes the intake register and the queue before the serializer loads its bytes.
// A two-entry queue lets intake run ahead while a frame is being sent.
// Reset is asynchronous, active low; slave address resets to 170.
// Output stalls hold the current byte; the CRC advances only as bytes load.
// ----------------------------------------------------------------------------
module modbus_read_request_framer
  import mrf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] start_address_i,
  input  logic [15:0] register_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_byte_o
);

  logic f_valid, f_ready;
  req_t f_req;
  logic q_valid, q_ready;
  req_t q_req;

  mrf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .start_address_i  (start_address_i),
    .register_count_i (register_count_i),
    .req_valid_o      (f_valid),
    .req_ready_i      (f_ready),
    .req_o            (f_req)
  );

  mrf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_req),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_req)
  );

  mrf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (q_valid),
    .req_ready_o  (q_ready),
    .req_i        (q_req),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Read request framer testbench: sends requests and slave address writes,
// builds most expected eight-byte frames with their CRC-16, takes two typed from its table, and checks every byte.
// ----------------------------------------------------------------------------
module tb_top
  import mrf_pkg::*;
;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldLen    = 300;
  localparam int unsigned DrainWait  = 12;
  localparam int unsigned PhaseItems = 50;
  localparam int unsigned DirRows    = 13;
  localparam int unsigned ShowLimit  = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_entry_t;

  typedef struct packed {
    logic        wr_slave;
    logic [7:0]  slave;
    logic [15:0] addr;
    logic [15:0] count;
    logic        typed;
    logic [63:0] frame;   // transmit order, first byte on top
  } dir_row_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_valid_i      = 1'b0;
  logic [7:0]  cfg_data_i       = 8'h00;
  logic        in_valid_i       = 1'b0;
  logic [15:0] start_address_i  = 16'h0000;
  logic [15:0] register_count_i = 16'h0000;
  logic        out_ready_i      = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  frame_byte_o;
  logic        last_byte_o;

  frame_entry_t frame_q [$];
  frame_entry_t want;
  logic [7:0]   slave_addr     = SlaveReset;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  hold_req       = 0;
  int unsigned  hold_seen      = 0;
  int unsigned  hold_left      = 0;
  int unsigned  errors         = 0;
  int unsigned  cycles         = 0;

  dir_row_t dir_tab [DirRows] = '{
    '{1'b0, 8'h00, 16'h0000, 16'h0000, 1'b0, 64'h0},
    '{1'b0, 8'h00, 16'hFFFF, 16'hFFFF, 1'b0, 64'h0},
    '{1'b0, 8'h00, 16'h0000, 16'hFFFF, 1'b0, 64'h0},
    '{1'b0, 8'h00, 16'hFFFF, 16'h0000, 1'b0, 64'h0},
    '{1'b0, 8'h00, 16'h0001, 16'h007D, 1'b0, 64'h0},
    '{1'b0, 8'h00, 16'h0001, 16'h007E, 1'b0, 64'h0},
    '{1'b1, 8'h01, 16'h0000, 16'h000A, 1'b1, 64'h0103_0000_000A_C5CD},
    '{1'b1, 8'h11, 16'h006B, 16'h0003, 1'b1, 64'h1103_006B_0003_7687},
    '{1'b1, 8'h00, 16'h8000, 16'h8000, 1'b0, 64'h0},
    '{1'b0, 8'h00, 16'h5555, 16'hAAAA, 1'b0, 64'h0},
    '{1'b1, 8'hFF, 16'hAAAA, 16'h5555, 1'b0, 64'h0},
    '{1'b0, 8'h00, 16'h1234, 16'h0001, 1'b0, 64'h0},
    '{1'b1, 8'hAA, 16'h00FF, 16'hFF00, 1'b0, 64'h0}
  };

  modbus_read_request_framer u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .start_address_i  (start_address_i),
    .register_count_i (register_count_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_byte_o     (frame_byte_o),
    .last_byte_o      (last_byte_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldLen;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_q.size() == 0) begin
        errors = errors + 1;
        if (errors <= ShowLimit) begin
          $display("unexpected byte %h last %b", frame_byte_o, last_byte_o);
        end
      end else begin
        want = frame_q.pop_front();
        if (frame_byte_o !== want.data || last_byte_o !== want.last) begin
          errors = errors + 1;
          if (errors <= ShowLimit) begin
            $display("byte mismatch: exp %h/%b got %h/%b",
                     want.data, want.last, frame_byte_o, last_byte_o);
          end
        end
      end
    end
  end

  function automatic logic [15:0] modbus_crc(input logic [47:0] body);
    logic [15:0] acc;
    acc = CrcInit;
    for (int k = 5; k >= 0; k--) begin
      acc = acc ^ {8'h00, body[k*8 +: 8]};
      for (int b = 0; b < 8; b++) begin
        acc = acc[0] ? ((acc >> 1) ^ CrcPoly) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] request_frame(input logic [15:0] addr,
                                                input logic [15:0] count);
    logic [47:0] body;
    logic [15:0] crc;
    body = {slave_addr, FuncReadHolding, addr, count};
    crc  = modbus_crc(body);
    return {body, crc[7:0], crc[15:8]};
  endfunction

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_slave(input logic [7:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    slave_addr = value;
  endtask

  task automatic send_req(input logic [15:0] addr, input logic [15:0] count,
                          input logic [63:0] frame);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    start_address_i  <= addr;
    register_count_i <= count;
    do @(posedge clk_i); while (!in_ready_o);
    for (int k = 0; k < FrameLen; k++) begin
      frame_q.push_back('{frame[63 - 8*k -: 8], k == FrameLen - 1});
    end
  endtask

  task automatic rand_req();
    logic [15:0] addr;
    logic [15:0] count;
    case ($urandom_range(3))
      0: begin
        addr  = 16'($urandom);
        count = 16'($urandom);
      end
      1: begin
        addr  = 16'($urandom);
        count = 16'($urandom_range(125, 1));
      end
      2: begin
        addr  = 16'($urandom_range(255));
        count = 16'($urandom_range(16));
      end
      default: begin
        addr  = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        count = $urandom_range(1) ? 16'hFFFF : 16'h007D;
      end
    endcase
    send_req(addr, count, request_frame(addr, count));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      if (dir_tab[r].wr_slave) write_slave(dir_tab[r].slave);
      send_req(dir_tab[r].addr, dir_tab[r].count,
               dir_tab[r].typed ? dir_tab[r].frame
                                : request_frame(dir_tab[r].addr, dir_tab[r].count));
    end

    for (int p = 0; p < 4; p++) begin
      write_slave(8'($urandom));
      case (p)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 77;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 77;
        end
        default: begin
          send_idle_pct  <= 18;
          recv_stall_pct <= 18;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 0 && n == 10) hold_req <= hold_req + 1;
        if (p == 1 && n == 25) wait_idle();
        rand_req();
      end
    end

    wait_idle();
    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/mrf_pkg.sv
hw/rtl/mrf_front.sv
hw/rtl/mrf_queue.sv
hw/rtl/mrf_back.sv
hw/rtl/modbus_read_request_framer.sv
test/tb_top.sv
